// File: hw/rtl/ffla_pkg.sv
// shared constants and codes for the fragment free list allocator
// no dependencies; used by the channel interfaces and the top level
package ffla_pkg;

    localparam int ADDR_BITS          = 48;
    localparam int DEFAULT_LIST_DEPTH = 64;
    localparam int OP_W               = 2;
    localparam int STATUS_W           = 2;
    localparam int FREE_COUNT_W       = 7;

    localparam logic [ADDR_BITS-1:0] FRAG_SIZE_RESET = ADDR_BITS'(65536);

    // item op codes
    localparam logic [OP_W-1:0] OP_CARVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// File: hw/rtl/ffla_if.sv
// valid/ready channel interfaces: request items, result items, config writes
// depends on ffla_pkg for field widths
interface ffla_req_if
    import ffla_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] region_size;

    modport source (output valid, output op, output address, output region_size,
                    input ready);
    modport sink   (input valid, input op, input address, input region_size,
                    output ready);
endinterface

interface ffla_rsp_if
    import ffla_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ADDR_BITS-1:0]    alloc_base;
    logic [STATUS_W-1:0]     status;
    logic [FREE_COUNT_W-1:0] free_count;

    modport source (output valid, output alloc_base, output status, output free_count,
                    input ready);
    modport sink   (input valid, input alloc_base, input status, input free_count,
                    output ready);
endinterface

interface ffla_cfg_if
    import ffla_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] frag_size;

    modport source (output valid, output frag_size, input ready);
    modport sink   (input valid, input frag_size, output ready);
endinterface

// File: hw/rtl/fragment_free_list_allocator.sv
// fragment free list allocator top level: sequencer, list memory, result register
// depends on ffla_pkg and the channel interfaces in ffla_if.sv
//
// usage:
//   req carries one item: op (carve, remove, allocate), address, region_size.
//   rsp returns exactly one item per request: alloc_base, status, free_count.
//   cfg writes frag_size; it is always ready; it is to be written only while idle, unchecked by the block.
// timing:
//   req.ready is high only while the sequencer is idle; one item at a time.
//   allocate: the head entry is read, then the result register is loaded.
//   carve: appends one fragment per cycle until the remainder is at most frag_size or the list is full.
//   remove: reads one list entry per cycle, with read and compact pipelined on
//   the single memory port pair.
//   the list memory has one write and one registered read port; the running
//   size/base adder pair is the shared unit that sets the carve rate.
// reset:
//   the list is empty, head at 0, frag_size 65536; memory contents are not
//   cleared and no entry is used before it is written.
// stalls:
//   a finished result waits in the output register while rsp.ready is low;
//   the next item may be taken meanwhile but its result waits for the slot.
module fragment_free_list_allocator
    import ffla_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ffla_req_if.sink   req,
    ffla_rsp_if.source rsp,
    ffla_cfg_if.sink   cfg
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CARVE,
        S_SCAN,
        S_ALLOC_RD,
        S_DONE
    } state_t;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(h) + (CNT_W+1)'(k);
        if (sum >= (CNT_W+1)'(LIST_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(LIST_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // list memory
    logic [ADDR_BITS-1:0] mem [LIST_DEPTH];
    logic [ADDR_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ADDR_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    state_t                  state_reg, state_next;
    logic [ADDR_BITS-1:0]    frag_reg;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [ADDR_BITS-1:0]    base_reg, base_next;
    logic [ADDR_BITS-1:0]    size_reg, size_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;
    logic                    pend_reg, pend_next;
    logic [ADDR_BITS-1:0]    res_base_reg, res_base_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]    out_base_reg, out_base_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [FREE_COUNT_W-1:0] out_count_reg, out_count_next;

    logic                 req_fire;
    logic [ADDR_BITS:0]   size_diff;
    logic                 size_gt;
    logic                 list_full;

    assign req.ready      = (state_reg == S_IDLE);
    assign req_fire       = req.valid && req.ready;
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.alloc_base = out_base_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.free_count = out_count_reg;

    // shared compare: remaining size strictly above frag_size
    assign size_diff = {1'b0, size_reg} - {1'b0, frag_reg};
    assign size_gt   = !size_diff[ADDR_BITS] && (size_diff[ADDR_BITS-1:0] != '0);
    assign list_full = (count_reg == CNT_W'(LIST_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        scan_idx_next   = scan_idx_reg;
        kept_next       = kept_reg;
        pend_next       = pend_reg;
        res_base_next   = res_base_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_base_next   = out_base_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_of(head_reg, count_reg);
        mem_wdata       = base_reg;
        mem_raddr       = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_base_next   = '0;
                    res_status_next = ST_OK;
                    base_next       = req.address;
                    size_next       = req.region_size;
                    scan_idx_next   = '0;
                    kept_next       = '0;
                    pend_next       = 1'b0;
                    priority if (req.op == OP_CARVE)
                    begin
                        state_next = S_CARVE;
                    end
                    else if (req.op == OP_REMOVE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.op == OP_ALLOC)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // read of the head entry is issued this cycle
                            state_next = S_ALLOC_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CARVE:
            begin
                if (!size_gt)
                begin
                    state_next = S_DONE;
                end
                else if (list_full)
                begin
                    res_status_next = ST_OVERFLOW;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    size_next  = size_diff[ADDR_BITS-1:0];
                    base_next  = base_reg + frag_reg;
                end
            end

            S_SCAN:
            begin
                // compact: entry read last cycle is kept unless it matches
                mem_waddr = slot_of(head_reg, kept_reg);
                mem_wdata = rdata_reg;
                if (pend_reg && (rdata_reg != base_reg))
                begin
                    mem_we    = 1'b1;
                    kept_next = kept_reg + 1'b1;
                end
                mem_raddr = slot_of(head_reg, scan_idx_reg);
                if (scan_idx_reg < count_reg)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = kept_reg;
                        state_next = S_DONE;
                    end
                end
            end

            S_ALLOC_RD:
            begin
                res_base_next = rdata_reg;
                head_next     = (head_reg == IDX_W'(LIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next    = count_reg - 1'b1;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_base_next   = res_base_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = FREE_COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frag_reg       <= FRAG_SIZE_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            base_reg       <= '0;
            size_reg       <= '0;
            scan_idx_reg   <= '0;
            kept_reg       <= '0;
            pend_reg       <= 1'b0;
            res_base_reg   <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_base_reg   <= '0;
            out_status_reg <= ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                frag_reg <= cfg.frag_size;
            end
            head_reg       <= head_next;
            count_reg      <= count_next;
            base_reg       <= base_next;
            size_reg       <= size_next;
            scan_idx_reg   <= scan_idx_next;
            kept_reg       <= kept_next;
            pend_reg       <= pend_next;
            res_base_reg   <= res_base_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_base_reg   <= out_base_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("free count above list depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= IDX_W'(LIST_DEPTH - 1))
        else $error("head index out of range");

    a_kept_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> kept_reg <= scan_idx_reg && scan_idx_reg <= count_reg)
        else $error("compaction pointer ahead of scan pointer");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY |-> rsp.alloc_base == '0 && rsp.free_count == '0)
        else $error("empty allocate result carries a base or a count");

    a_alloc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.op == OP_ALLOC && count_reg == '0
        |=> state_reg == S_DONE && res_status_reg == ST_EMPTY)
        else $error("allocate on empty list not flagged");
`endif

endmodule

// File: tb/testbench.sv
// self-checking testbench for fragment_free_list_allocator: directed and random items
// depends on ffla_pkg, the channel interfaces in ffla_if.sv and the top level rtl
module testbench;
    import ffla_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_LIST_DEPTH;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0]    alloc_base;
        logic [STATUS_W-1:0]     status;
        logic [FREE_COUNT_W-1:0] free_count;
    } rsp_fields_t;

    class frag_list_scoreboard;
        logic [ADDR_BITS-1:0] frag_size;
        logic [ADDR_BITS-1:0] slots [LIST_DEPTH];
        int unsigned          head;
        int unsigned          held;
        rsp_fields_t          awaited [$];
        int                   mismatches;
        int                   checked;
        int                   carves;
        int                   overflows;
        int                   removes;
        int                   empties;

        function new();
            frag_size  = FRAG_SIZE_RESET;
            head       = 0;
            held       = 0;
            mismatches = 0;
            checked    = 0;
            carves     = 0;
            overflows  = 0;
            removes    = 0;
            empties    = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ADDR_BITS-1:0] address,
                                   logic [ADDR_BITS-1:0] region_size);
            rsp_fields_t          r;
            logic [ADDR_BITS-1:0] left;
            logic [ADDR_BITS-1:0] run;
            int unsigned          kept;
            r.alloc_base = '0;
            r.status     = ST_OK;
            case (op)
                OP_CARVE:
                begin
                    carves++;
                    left = region_size;
                    run  = address;
                    // a remainder equal to frag_size is not carved
                    while (left > frag_size && r.status == ST_OK)
                    begin
                        if (held >= LIST_DEPTH)
                            r.status = ST_OVERFLOW;
                        else
                        begin
                            slots[(head + held) % LIST_DEPTH] = run;
                            held++;
                            left = left - frag_size;
                            run  = run + frag_size;
                        end
                    end
                    if (r.status == ST_OVERFLOW)
                        overflows++;
                end
                OP_REMOVE:
                begin
                    removes++;
                    kept = 0;
                    for (int unsigned k = 0; k < held; k++)
                    begin
                        if (slots[(head + k) % LIST_DEPTH] != address)
                        begin
                            slots[(head + kept) % LIST_DEPTH] = slots[(head + k) % LIST_DEPTH];
                            kept++;
                        end
                    end
                    held = kept;
                end
                OP_ALLOC:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                        empties++;
                    end
                    else
                    begin
                        r.alloc_base = slots[head];
                        head = (head + 1) % LIST_DEPTH;
                        held--;
                    end
                end
                default: ;
            endcase
            r.free_count = FREE_COUNT_W'(held);
            awaited.push_back(r);
        endfunction

        function void check_response(rsp_fields_t got);
            rsp_fields_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("error: result with no item pending: base %h status %0d count %0d",
                             got.alloc_base, got.status, got.free_count);
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (got.alloc_base !== want.alloc_base || got.status !== want.status ||
                    got.free_count !== want.free_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("mismatch on result %0d: expected base %h status %0d count %0d",
                               checked, want.alloc_base, want.status, want.free_count);
                        $display(", got base %h status %0d count %0d",
                                 got.alloc_base, got.status, got.free_count);
                    end
                end
            end
        endfunction

        // a base currently on the list when it holds any, so that removes hit something
        function logic [ADDR_BITS-1:0] pick_live();
            logic [63:0] w;
            w = {$urandom, $urandom};
            if (held == 0)
                return w[ADDR_BITS-1:0];
            return slots[(head + $urandom_range(0, held - 1)) % LIST_DEPTH];
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   items_sent = 0;
    int   cfg_writes = 0;

    frag_list_scoreboard sb;

    ffla_req_if req_ch ();
    ffla_rsp_if rsp_ch ();
    ffla_cfg_if cfg_ch ();

    fragment_free_list_allocator #(
        .LIST_DEPTH (LIST_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    // result side: random back-pressure bursts until the calm part of the run
    always @(posedge clk)
    begin
        if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left > 0 && !calm)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rsp_fields_t got;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.alloc_base = rsp_ch.alloc_base;
            got.status     = rsp_ch.status;
            got.free_count = rsp_ch.free_count;
            sb.check_response(got);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL fragment_free_list_allocator");
            $finish;
        end
    end

    function automatic logic [ADDR_BITS-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_BITS-1:0];
    endfunction

    // mostly whole multiples of frag_size, exactly at them, one above or part way to the next
    function automatic logic [ADDR_BITS-1:0] carve_size();
        logic [ADDR_BITS-1:0] whole;
        logic [ADDR_BITS-1:0] extra;
        if ($urandom_range(0, 9) == 0)
            return rand48();
        whole = sb.frag_size * ADDR_BITS'($urandom_range(0, 4));
        case ($urandom_range(0, 2))
            0:       extra = '0;
            1:       extra = ADDR_BITS'(1);
            default: extra = (sb.frag_size > 1) ? rand48() % sb.frag_size : '0;
        endcase
        return whole + extra;
    endfunction

    // some regions sit just below the top so the running base wraps
    function automatic logic [ADDR_BITS-1:0] carve_base();
        if ($urandom_range(0, 4) == 0)
            return '1 - sb.frag_size * ADDR_BITS'($urandom_range(0, 3))
                   - ADDR_BITS'($urandom_range(0, 1));
        return rand48();
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] address,
                             input logic [ADDR_BITS-1:0] region_size);
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.address     <= address;
        req_ch.region_size <= region_size;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(op, address, region_size);
        items_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frag(input logic [ADDR_BITS-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.frag_size <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.frag_size = value;
        cfg_writes++;
    endtask

    task automatic run_random(input int count, input int idle_pct);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (!calm && $urandom_range(0, 99) < idle_pct)
                idle_sender($urandom_range(1, 16));
            if (pick < 30)
                send_item(OP_CARVE, carve_base(), carve_size());
            else if (pick < 72)
                send_item(OP_ALLOC, rand48(), rand48());
            else if (pick < 94)
                send_item(OP_REMOVE, ($urandom_range(0, 9) < 7) ? sb.pick_live() : rand48(),
                          rand48());
            else
                send_item(OP_UNUSED, rand48(), rand48());
        end
    endtask

    task automatic run_directed();
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_UNUSED, '1, '1);
        send_item(OP_CARVE, '0, '0);
        send_item(OP_CARVE, '0, 48'h0000_0001_0000);
        send_item(OP_CARVE, 48'h0000_0000_1000, 48'h0000_0001_0001);
        send_item(OP_CARVE, 48'hFFFF_FFFF_0000, 48'h0000_0003_0001);
        send_item(OP_REMOVE, 48'h0000_0000_1234, '0);
        send_item(OP_REMOVE, '0, '0);
        repeat (4) send_item(OP_ALLOC, '0, '0);
        // fill the list, then carve into it while full
        send_item(OP_CARVE, 48'hAAAA_AAAA_0000, '1);
        send_item(OP_CARVE, 48'h0000_0000_0001, 48'h0000_0002_0000);
        send_item(OP_CARVE, 48'h0000_0000_0001, 48'h0000_0001_0000);
        send_item(OP_REMOVE, 48'hAAAA_AAAA_0000, '1);
        send_item(OP_REMOVE, '1, '0);
        repeat (2) send_item(OP_ALLOC, '0, '0);
        drain();
        // zero fragment size repeats one base until the list is full
        write_frag('0);
        send_item(OP_CARVE, 48'h5555_5555_5555, 48'h0000_0000_0001);
        send_item(OP_CARVE, 48'h5555_5555_5555, '0);
        send_item(OP_REMOVE, 48'h5555_5555_5555, '0);
        send_item(OP_ALLOC, '0, '0);
        drain();
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_CARVE;
        req_ch.address     = '0;
        req_ch.region_size = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.frag_size   = FRAG_SIZE_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        write_frag(ADDR_BITS'(1));
        run_random(260, 25);
        drain();
        write_frag(ADDR_BITS'(16));
        run_random(260, 40);
        drain();
        write_frag(48'h8000_0000_0000);
        run_random(120, 25);
        drain();
        write_frag('1);
        run_random(80, 10);
        drain();
        write_frag('0);
        run_random(40, 25);
        drain();
        write_frag(48'h0000_0000_1000);
        run_random(300, 0);
        drain();
        write_frag(ADDR_BITS'($urandom_range(2, 1 << 20)));
        run_random(240, 30);
        drain();
        // last part runs with no idling on either side
        calm = 1'b1;
        write_frag(FRAG_SIZE_RESET);
        run_random(300, 0);
        drain();

        repeat (LIST_DEPTH + 8) @(posedge clk);
        if (sb.awaited.size() != 0)
        begin
            sb.mismatches += sb.awaited.size();
            $display("error: %0d results never arrived", sb.awaited.size());
        end
        $display("covered %0d items over %0d fragment sizes: %0d carves (%0d overflowed),",
                 items_sent, cfg_writes, sb.carves, sb.overflows);
        $display("%0d removes, %0d allocates on an empty list; %0d results checked, %0d mismatches",
                 sb.removes, sb.empties, sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS fragment_free_list_allocator");
        else
            $display("FAIL fragment_free_list_allocator");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ffla_pkg.sv
hw/rtl/ffla_if.sv
hw/rtl/fragment_free_list_allocator.sv
tb/testbench.sv
